>>> rtl/core/qats_pkg.sv
// Shared types and constants for the three-way queue-actuated signal core.
// Holds street codes, stream field offsets and the item/result structs.
// No dependencies.
`default_nettype none

package qats_pkg;

    localparam logic [1:0] STREET_A = 2'd0;
    localparam logic [1:0] STREET_B = 2'd1;
    localparam logic [1:0] STREET_C = 2'd2;

    localparam int NUM_STREETS = 3;
    localparam int TDATA_W     = 32;
    localparam int OUT_Q_W     = 8;
    localparam int START_W     = 8;
    localparam int TIMER_W     = 4;

    localparam logic [TIMER_W-1:0] MAX_GREEN_RESET = 4'd10;

    localparam int ARRIVE_LSB  = 0;
    localparam int START_A_LSB = 3;
    localparam int START_B_LSB = START_A_LSB + START_W;
    localparam int START_C_LSB = START_B_LSB + START_W;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [2:0]         arrive;
        logic [START_W-1:0] start_c;
        logic [START_W-1:0] start_b;
        logic [START_W-1:0] start_a;
    } in_item_t;

    typedef struct packed {
        logic               switched;
        logic [OUT_Q_W-1:0] queue_c;
        logic [OUT_Q_W-1:0] queue_b;
        logic [OUT_Q_W-1:0] queue_a;
        logic [1:0]         green_street;
    } result_t;

    function automatic logic [1:0] street_after(input logic [1:0] s);
        logic [1:0] r;
        if (s >= STREET_C)
        begin
            r = STREET_A;
        end
        else
        begin
            r = s + 2'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/qats_step.sv
// Next-state and result logic for one item of the signal core.
// Purely combinational; depends on qats_pkg.
`default_nettype none

module qats_step
    import qats_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
)
(
    input  var in_item_t               item,
    input  var logic [TIMER_W-1:0]     max_green,
    input  var logic [1:0]             phase,
    input  var logic [TIMER_W-1:0]     timer,
    input  var logic [COUNT_WIDTH-1:0] count [NUM_STREETS],
    output var logic [1:0]             phase_next,
    output var logic [TIMER_W-1:0]     timer_next,
    output var logic [COUNT_WIDTH-1:0] count_next [NUM_STREETS],
    output var result_t                res
);

    localparam int EW = (COUNT_WIDTH > START_W) ? COUNT_WIDTH : START_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    function automatic logic [COUNT_WIDTH-1:0] clamp_start(input logic [START_W-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        return (ext > EW'(CNT_MAX)) ? CNT_MAX : COUNT_WIDTH'(ext);
    endfunction

    function automatic logic [OUT_Q_W-1:0] sat_out(input logic [COUNT_WIDTH-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        return (ext > EW'({OUT_Q_W{1'b1}})) ? {OUT_Q_W{1'b1}} : OUT_Q_W'(ext);
    endfunction

    logic [COUNT_WIDTH-1:0] st_cnt [NUM_STREETS];
    logic [COUNT_WIDTH-1:0] arr    [NUM_STREETS];
    logic [COUNT_WIDTH-1:0] tk     [NUM_STREETS];
    logic [1:0]             st_pick;
    logic [1:0]             g;
    logic [1:0]             n1;
    logic [1:0]             n2;
    logic [TIMER_W:0]       t_inc;
    logic                   force_move;
    logic [1:0]             tk_phase;
    logic [TIMER_W-1:0]     tk_timer;
    logic [TIMER_W-1:0]     reload;

    assign st_cnt[0] = clamp_start(item.start_a);
    assign st_cnt[1] = clamp_start(item.start_b);
    assign st_cnt[2] = clamp_start(item.start_c);

    always_comb
    begin
        priority if (st_cnt[0] >= st_cnt[1] && st_cnt[0] >= st_cnt[2])
        begin
            st_pick = STREET_A;
        end
        else if (st_cnt[1] >= st_cnt[2])
        begin
            st_pick = STREET_B;
        end
        else
        begin
            st_pick = STREET_C;
        end
    end

    assign g  = (phase > STREET_C) ? STREET_A : phase;
    assign n1 = street_after(g);
    assign n2 = street_after(n1);

    always_comb
    begin
        for (int i = 0; i < NUM_STREETS; i++)
        begin
            arr[i] = (count[i] == CNT_MAX) ? count[i] : count[i] + COUNT_WIDTH'(item.arrive[i]);
            tk[i]  = arr[i];
            if (2'(i) == g && arr[i] != '0)
            begin
                tk[i] = arr[i] - COUNT_WIDTH'(1);
            end
        end
    end

    assign t_inc      = {1'b0, timer} + (TIMER_W+1)'(1);
    assign force_move = (t_inc > {1'b0, max_green}) || (tk[g] == '0);
    assign reload     = (max_green != '0) ? max_green - TIMER_W'(1) : '0;

    always_comb
    begin
        tk_phase = g;
        tk_timer = TIMER_W'(t_inc);
        if (force_move)
        begin
            priority if (tk[n1] != '0)
            begin
                tk_phase = n1;
                tk_timer = '0;
            end
            else if (tk[n2] != '0)
            begin
                tk_phase = n2;
                tk_timer = '0;
            end
            else
            begin
                tk_timer = reload;
            end
        end
    end

    always_comb
    begin
        unique case (item.mode)
            MODE_START:
            begin
                phase_next = st_pick;
                timer_next = '0;
                count_next = st_cnt;
            end
            default:
            begin
                phase_next = tk_phase;
                timer_next = tk_timer;
                count_next = tk;
            end
        endcase
    end

    assign res.green_street = phase_next;
    assign res.queue_a      = sat_out(count_next[0]);
    assign res.queue_b      = sat_out(count_next[1]);
    assign res.queue_c      = sat_out(count_next[2]);
    assign res.switched     = (phase_next != phase);

endmodule

`default_nettype wire

>>> rtl/core/queue_actuated_three_way_signal_core.sv
// Top level of the three-way queue-actuated signal controller.
// Input register, state registers and result register; uses qats_pkg and qats_step.
//
// Each accepted item yields one result: it is first captured in the input
// register, then the step logic writes the queues, phase, timer and result
// register together. Sustained rate is one item per cycle while m_tready is high;
// the input register advances whenever the result register is empty or being
// taken, so s_tready follows m_tready combinationally when both stages are full.
`default_nettype none

module queue_actuated_three_way_signal_core
    import qats_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
)
(
    input  var logic                 clk,
    input  var logic                 rst_n,
    input  var logic                 cfg_we,
    input  var logic [TIMER_W-1:0]   cfg_data,   // max_green
    input  var logic                 s_tvalid,
    output var logic                 s_tready,
    input  var logic [TDATA_W-1:0]   s_tdata,    // arrive_a, arrive_b, arrive_c, start_a,
                                                 // start_b, start_c, zero fill
    input  var logic                 s_tuser,    // mode
    output var logic                 m_tvalid,
    input  var logic                 m_tready,
    output var logic [TDATA_W-1:0]   m_tdata     // green_street, queue_a, queue_b, queue_c,
                                                 // switched, zero fill
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    in_item_t               in_item_reg;
    in_item_t               in_item;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_res_reg;
    result_t                res;
    logic [TIMER_W-1:0]     max_green_reg;
    logic [1:0]             phase_reg;
    logic [1:0]             phase_next;
    logic [TIMER_W-1:0]     timer_reg;
    logic [TIMER_W-1:0]     timer_next;
    logic [COUNT_WIDTH-1:0] count_reg  [NUM_STREETS];
    logic [COUNT_WIDTH-1:0] count_next [NUM_STREETS];
    logic                   s_xfer;
    logic                   advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign in_item.mode    = s_tuser;
    assign in_item.arrive  = s_tdata[ARRIVE_LSB +: 3];
    assign in_item.start_a = s_tdata[START_A_LSB +: START_W];
    assign in_item.start_b = s_tdata[START_B_LSB +: START_W];
    assign in_item.start_c = s_tdata[START_C_LSB +: START_W];

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    qats_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .item       (in_item_reg),
        .max_green  (max_green_reg),
        .phase      (phase_reg),
        .timer      (timer_reg),
        .count      (count_reg),
        .phase_next (phase_next),
        .timer_next (timer_next),
        .count_next (count_next),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_green_reg <= MAX_GREEN_RESET;
            phase_reg     <= STREET_A;
            timer_reg     <= '0;
            for (int i = 0; i < NUM_STREETS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                max_green_reg <= cfg_data;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                timer_reg <= timer_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_res_reg);

endmodule

`default_nettype wire

>>> rtl/core/qats_checker.sv
// Port-level checks for the three-way signal core, bound to its top level.
// Watches the output stream and the input handshake; depends on qats_pkg.
`default_nettype none

module qats_checker
    import qats_pkg::*;
(
    input var logic               clk,
    input var logic               rst_n,
    input var logic               s_tvalid,
    input var logic               s_tready,
    input var logic               m_tvalid,
    input var logic               m_tready,
    input var logic [TDATA_W-1:0] m_tdata
);

    result_t    res;
    logic [1:0] last_green_reg;

    assign res = result_t'(m_tdata[$bits(result_t)-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_green_reg <= STREET_A;
        end
        else if (m_tvalid && m_tready)
        begin
            last_green_reg <= res.green_street;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_street: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.green_street != 2'd3)
        else $error("green street code out of range");

    a_switch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.switched == (res.green_street != last_green_reg))
        else $error("switched flag disagrees with previous green street");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[TDATA_W-1:$bits(result_t)] == '0)
        else $error("fill bits of result not zero");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready || !s_tvalid || $past(s_tvalid && s_tready))
        else $error("input stalled with empty output and no item in flight");

endmodule

bind queue_actuated_three_way_signal_core qats_checker u_qats_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
